/* design/smpc_pkg.sv */
// Shared types and constants for the soil moisture pump controller.
package smpc_pkg;

    localparam int TIME_W    = 32;
    localparam int DUR_W     = 20;
    localparam int CMP_W     = (TIME_W > DUR_W) ? TIME_W : DUR_W;
    localparam int RAW_W     = 10;
    localparam int PCT_W     = 7;
    localparam int NOW_W     = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int RAW_DRY   = 1023;
    localparam int RAW_WET   = 300;
    localparam int PCT_MAX   = 100;
    localparam int PCT_SPAN  = RAW_DRY - RAW_WET;
    // floor(d * 100 / 723) == (d * PCT_MUL) >> PCT_SHIFT for d < 723
    localparam int PCT_SHIFT = 20;
    localparam int PCT_MUL   = ((PCT_MAX << PCT_SHIFT) + PCT_SPAN - 1) / PCT_SPAN;
    localparam int PROD_W    = 28;

    localparam logic [PCT_W-1:0] LOW_THR_RST  = PCT_W'(30);
    localparam logic [PCT_W-1:0] HIGH_THR_RST = PCT_W'(45);
    localparam logic [DUR_W-1:0] MAX_WATER_RST = DUR_W'(1000);
    localparam logic [DUR_W-1:0] MIN_GAP_RST   = DUR_W'(10000);
    localparam logic [DUR_W-1:0] SETTLE_RST    = DUR_W'(5000);

    typedef enum logic [2:0] {
        REG_LOW_THR   = 3'd0,
        REG_HIGH_THR  = 3'd1,
        REG_MAX_WATER = 3'd2,
        REG_MIN_GAP   = 3'd3,
        REG_SETTLE    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PCT_W-1:0] low_thr;
        logic [PCT_W-1:0] high_thr;
        logic [DUR_W-1:0] max_water_ms;
        logic [DUR_W-1:0] min_gap_ms;
        logic [DUR_W-1:0] settle_ms;
    } cfg_t;

    typedef struct packed {
        logic pump_on;
        logic wants_water;
        logic settling;
    } status_t;

endpackage

/* design/smpc_cfg.sv */
// APB register file holding thresholds and timing limits.
module smpc_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smpc_pkg::ADDR_W-1:0] paddr,
    input  logic [smpc_pkg::DATA_W-1:0] pwdata,
    output logic [smpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output smpc_pkg::cfg_t              cfg
);
    import smpc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_thr      <= LOW_THR_RST;
            cfg_reg.high_thr     <= HIGH_THR_RST;
            cfg_reg.max_water_ms <= MAX_WATER_RST;
            cfg_reg.min_gap_ms   <= MIN_GAP_RST;
            cfg_reg.settle_ms    <= SETTLE_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_LOW_THR:   cfg_reg.low_thr      <= pwdata[PCT_W-1:0];
                REG_HIGH_THR:  cfg_reg.high_thr     <= pwdata[PCT_W-1:0];
                REG_MAX_WATER: cfg_reg.max_water_ms <= pwdata[DUR_W-1:0];
                REG_MIN_GAP:   cfg_reg.min_gap_ms   <= pwdata[DUR_W-1:0];
                REG_SETTLE:    cfg_reg.settle_ms    <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LOW_THR:   prdata = DATA_W'(cfg_reg.low_thr);
            REG_HIGH_THR:  prdata = DATA_W'(cfg_reg.high_thr);
            REG_MAX_WATER: prdata = DATA_W'(cfg_reg.max_water_ms);
            REG_MIN_GAP:   prdata = DATA_W'(cfg_reg.min_gap_ms);
            REG_SETTLE:    prdata = DATA_W'(cfg_reg.settle_ms);
            default:       prdata = '0;
        endcase
    end

endmodule

/* design/smpc_pct.sv */
// Raw sample to clamped moisture percentage.
module smpc_pct (
    input  logic [smpc_pkg::RAW_W-1:0] raw,
    output logic [smpc_pkg::PCT_W-1:0] pct
);
    import smpc_pkg::*;

    logic [RAW_W-1:0]  dry_diff;
    logic [PROD_W-1:0] prod;

    assign dry_diff = RAW_W'(RAW_DRY) - raw;
    assign prod     = PROD_W'(dry_diff) * PROD_W'(PCT_MUL);
    assign pct      = (dry_diff >= RAW_W'(PCT_SPAN)) ? PCT_W'(PCT_MAX)
                                                     : prod[PCT_SHIFT +: PCT_W];

endmodule

/* design/smpc_ctrl.sv */
// Need hysteresis and idle / watering / settling pump sequencer.
module smpc_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [smpc_pkg::PCT_W-1:0]  pct,
    input  logic [smpc_pkg::TIME_W-1:0] now,
    input  smpc_pkg::cfg_t              cfg,
    output smpc_pkg::status_t           status
);
    import smpc_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_WATER  = 3'b010,
        MODE_SETTLE = 3'b100
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic              need_reg, need_next;
    logic [TIME_W-1:0] start_time_reg, start_time_next;
    logic [TIME_W-1:0] stop_time_reg, stop_time_next;

    logic              lo_hit, hi_hit, need_h;
    logic [TIME_W-1:0] el_stop, el_pump;
    logic              settle_done, gap_done, pump_done;

    always_comb begin
        lo_hit      = pct <= cfg.low_thr;
        hi_hit      = pct >= cfg.high_thr;
        need_h      = lo_hit ? 1'b1 : (hi_hit ? 1'b0 : need_reg);
        el_stop     = now - stop_time_reg;
        el_pump     = now - start_time_reg;
        settle_done = CMP_W'(el_stop) >= CMP_W'(cfg.settle_ms);
        gap_done    = CMP_W'(el_stop) >= CMP_W'(cfg.min_gap_ms);
        pump_done   = CMP_W'(el_pump) >= CMP_W'(cfg.max_water_ms);

        mode_next       = mode_reg;
        need_next       = need_h;
        start_time_next = start_time_reg;
        stop_time_next  = stop_time_reg;
        unique case (mode_reg)
            MODE_SETTLE: begin
                if (settle_done) begin
                    mode_next = MODE_IDLE;
                    need_next = lo_hit;
                end
            end
            MODE_WATER: begin
                if (!need_h || hi_hit || pump_done) begin
                    mode_next      = MODE_SETTLE;
                    stop_time_next = now;
                end
            end
            MODE_IDLE: begin
                if (need_h && lo_hit && gap_done) begin
                    mode_next       = MODE_WATER;
                    start_time_next = now;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        status.pump_on     = mode_next == MODE_WATER;
        status.wants_water = need_next;
        status.settling    = mode_next == MODE_SETTLE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            need_reg       <= 1'b0;
            start_time_reg <= '0;
            stop_time_reg  <= '0;
        end else if (step) begin
            mode_reg       <= mode_next;
            need_reg       <= need_next;
            start_time_reg <= start_time_next;
            stop_time_reg  <= stop_time_next;
        end
    end

    a_start_needs_water: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == MODE_IDLE && mode_next == MODE_WATER |-> need_h && lo_hit)
        else $error("pump started without need");

    a_stop_time_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == MODE_WATER && mode_next == MODE_SETTLE
        |=> stop_time_reg == $past(now))
        else $error("stop time not recorded");

    a_no_idle_to_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && mode_reg == MODE_IDLE |-> mode_next != MODE_SETTLE)
        else $error("settling entered from idle");

    a_hold_without_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(need_reg))
        else $error("state changed without a word");

endmodule

/* design/soil_moisture_pump_controller_unit.sv */
// Top level of the soil moisture pump controller.
//
// Input channel (s_*): one word per moisture sample, raw reading plus its
// millisecond timestamp. Output channel (m_*): one word per sample with the
// clamped percentage and the pump, need and settling flags after the sample.
// Both use valid/ready; a word moves when valid and ready are high together.
// A word goes from the input register through the percentage map and the
// mode sequencer into the result register, which drives m_valid. Throughput
// is one word per cycle while m_ready stays high; the controller state
// advances in the same cycle a word moves from the input register to the
// result register. When the receiver stalls, the result register holds and
// the input register keeps one more word, after which s_ready drops until
// m_ready returns. Reset (aresetn low, synchronous) empties both registers,
// puts the sequencer in idle with no need, zeroes the time marks and reloads
// the configuration defaults. The user must write registers over the APB port
// only while no word is in flight; the block itself does not enforce it.
module soil_moisture_pump_controller_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [smpc_pkg::RAW_W-1:0]  s_raw_sample,
    input  logic [smpc_pkg::NOW_W-1:0]  s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [smpc_pkg::PCT_W-1:0]  m_moisture_pct,
    output logic                        m_pump_on,
    output logic                        m_wants_water,
    output logic                        m_settling,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [smpc_pkg::ADDR_W-1:0] paddr,
    input  logic [smpc_pkg::DATA_W-1:0] pwdata,
    output logic [smpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import smpc_pkg::*;

    cfg_t             cfg;
    logic             in_valid_reg;
    logic [RAW_W-1:0] raw_reg;
    logic [NOW_W-1:0] now_reg;
    logic             out_valid_reg;
    logic [PCT_W-1:0] pct_reg;
    status_t          status_reg;
    logic [PCT_W-1:0] pct;
    status_t          status;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    smpc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smpc_pct u_pct (
        .raw (raw_reg),
        .pct (pct)
    );

    smpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .pct     (pct),
        .now     (TIME_W'(now_reg)),
        .cfg     (cfg),
        .status  (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            raw_reg <= s_raw_sample;
            now_reg <= s_now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pct_reg    <= pct;
            status_reg <= status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_moisture_pct = pct_reg;
    assign m_pump_on      = status_reg.pump_on;
    assign m_wants_water  = status_reg.wants_water;
    assign m_settling     = status_reg.settling;

    a_pump_settle_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_pump_on && m_settling))
        else $error("pump running while settling");

    a_free_output_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word stuck in input register");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_moisture_pct <= PCT_W'(PCT_MAX))
        else $error("percentage out of range");

endmodule
